// File: src/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants for integer to ASCII conversion
// Holds the job control word that travels between the front and back parts,
// the character codes and the digit to character mapping.
// ----------------------------------------------------------------------------
package itoa_pkg;

	localparam int RADIX_W = 6;
	localparam int CHAR_W  = 8;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

	localparam logic [CHAR_W-1:0] CHAR_NUL         = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_MINUS       = 8'h2d;
	localparam logic [CHAR_W-1:0] CHAR_ZERO        = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_LETTER_BASE = 8'h57;

	typedef struct packed {
		logic               bad;
		logic               neg;
		logic [RADIX_W-1:0] radix;
	} job_ctl_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] wide;
		wide = {2'b00, d};
		if (d < DEC_DIGITS) begin
			return CHAR_ZERO + wide;
		end
		return CHAR_LETTER_BASE + wide;
	endfunction

endpackage

// File: src/integer_to_ascii_radix_top.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_top: signed integer to ASCII text, radix 2 to 36
//
//   Channel   Direction   Handshake              Payload
//   input     in          in_valid / in_ready    number, radix
//   output    out         out_valid / out_ready  character, bad_radix, last_char
//
// Each digit is formed in the radix divider, and each character then leaves
// through the digit stack's registered read port, read in ST_RD and sent in
// ST_OUT; a sign adds the ST_SIGN state ahead of the digits. A bad radix
// gives a single beat.
// Reset clears the queue, the sequencer and the output valid; no clearing
// pass is needed. A stalled output holds the engine, and the two-entry queue
// keeps accepting input beats until it is full.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_top #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [VALUE_WIDTH-1:0]     number,
	input  logic [itoa_pkg::RADIX_W-1:0]      radix,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [itoa_pkg::CHAR_W-1:0]       character,
	output logic                              bad_radix,
	output logic                              last_char
);

	localparam int CTL_W = $bits(itoa_pkg::job_ctl_t);
	localparam int JOB_W = CTL_W + VALUE_WIDTH;

	logic                     push_valid;
	logic                     push_ready;
	itoa_pkg::job_ctl_t       push_ctl;
	logic [VALUE_WIDTH-1:0]   push_mag;
	logic                     job_valid;
	logic                     job_ready;
	logic [JOB_W-1:0]         job_data;
	itoa_pkg::job_ctl_t       job_ctl;
	logic [VALUE_WIDTH-1:0]   job_mag;

	assign job_ctl = itoa_pkg::job_ctl_t'(job_data[JOB_W-1:VALUE_WIDTH]);
	assign job_mag = job_data[VALUE_WIDTH-1:0];

	itoa_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.number    (number),
		.radix     (radix),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_ctl  (push_ctl),
		.push_mag  (push_mag)
	);

	itoa_fifo #(
		.WIDTH(JOB_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data ({push_ctl, push_mag}),
		.pop_valid (job_valid),
		.pop_ready (job_ready),
		.pop_data  (job_data)
	);

	itoa_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job_ctl   (job_ctl),
		.job_mag   (job_mag),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.character (character),
		.bad_radix (bad_radix),
		.last_char (last_char)
	);

endmodule

// File: src/itoa_front.sv
// ----------------------------------------------------------------------------
// itoa_front: input side of the converter
// Accepts input beats, checks the radix, splits the sign from the magnitude
// and hands the job to the queue.
// ----------------------------------------------------------------------------
module itoa_front #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [VALUE_WIDTH-1:0]     number,
	input  logic [itoa_pkg::RADIX_W-1:0]      radix,
	output logic                              push_valid,
	input  logic                              push_ready,
	output itoa_pkg::job_ctl_t                push_ctl,
	output logic [VALUE_WIDTH-1:0]            push_mag
);

	logic [VALUE_WIDTH-1:0] raw;

	assign raw        = $unsigned(number);
	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	always_comb begin
		push_ctl.bad   = (radix < itoa_pkg::RADIX_MIN) || (radix > itoa_pkg::RADIX_MAX);
		push_ctl.neg   = raw[VALUE_WIDTH-1];
		push_ctl.radix = radix;
		push_mag       = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
	end

endmodule

// File: src/itoa_fifo.sv
// ----------------------------------------------------------------------------
// itoa_fifo: two-entry job queue
// Decouples the front from the back so that either side can stall alone.
// ----------------------------------------------------------------------------
module itoa_fifo #(
	parameter int WIDTH = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

endmodule

// File: src/itoa_back.sv
// ----------------------------------------------------------------------------
// itoa_back: conversion engine
// Divides the magnitude by the radix eight quotient bits a cycle, pushes each
// remainder as a character onto a digit stack, then drains the stack most
// significant character first behind an optional minus sign.
// ----------------------------------------------------------------------------
module itoa_back #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	output logic                          job_ready,
	input  itoa_pkg::job_ctl_t            job_ctl,
	input  logic [VALUE_WIDTH-1:0]        job_mag,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [itoa_pkg::CHAR_W-1:0]   character,
	output logic                          bad_radix,
	output logic                          last_char
);

	localparam int DIV_BITS  = 8;
	localparam int DIV_STEPS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
	localparam int PAD_W     = DIV_STEPS * DIV_BITS;
	localparam int SC_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
	localparam int AW        = $clog2(VALUE_WIDTH);
	localparam int ND_W      = $clog2(VALUE_WIDTH + 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_DIV  = 6'b000010,
		ST_SIGN = 6'b000100,
		ST_RD   = 6'b001000,
		ST_OUT  = 6'b010000,
		ST_BAD  = 6'b100000
	} state_t;

	state_t                          state_q;
	logic [PAD_W-1:0]                dvd_q;
	logic [itoa_pkg::RADIX_W-1:0]    rem_q;
	logic [itoa_pkg::RADIX_W-1:0]    rad_q;
	logic                            neg_q;
	logic [SC_W-1:0]                 step_q;
	logic [ND_W-1:0]                 nd_q;
	logic [AW-1:0]                   rd_ptr_q;
	logic [itoa_pkg::CHAR_W-1:0]     rd_data_q;
	logic [itoa_pkg::CHAR_W-1:0]     stack_q [VALUE_WIDTH];
	logic                            out_valid_q;
	logic [itoa_pkg::CHAR_W-1:0]     char_q;
	logic                            bad_q;
	logic                            last_q;

	logic [PAD_W-1:0]                dvd_nxt;
	logic [itoa_pkg::RADIX_W-1:0]    rem_nxt;
	logic [itoa_pkg::RADIX_W:0]      trial;
	logic                            digit_done;
	logic                            out_free;
	logic                            pop;

	assign out_free   = !out_valid_q || out_ready;
	assign job_ready  = (state_q == ST_IDLE);
	assign pop        = job_valid && job_ready;
	assign digit_done = (state_q == ST_DIV) && (step_q == SC_W'(DIV_STEPS - 1));
	assign out_valid  = out_valid_q;
	assign character  = char_q;
	assign bad_radix  = bad_q;
	assign last_char  = last_q;

	always_comb begin
		dvd_nxt = dvd_q;
		rem_nxt = rem_q;
		trial   = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			trial   = {rem_nxt, dvd_nxt[PAD_W-1]};
			dvd_nxt = {dvd_nxt[PAD_W-2:0], 1'b0};
			if (trial >= {1'b0, rad_q}) begin
				trial      = trial - {1'b0, rad_q};
				dvd_nxt[0] = 1'b1;
			end
			rem_nxt = trial[itoa_pkg::RADIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			nd_q        <= '0;
			rd_ptr_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						step_q  <= '0;
						nd_q    <= '0;
						state_q <= job_ctl.bad ? ST_BAD : ST_DIV;
					end
				end
				ST_DIV: begin
					if (digit_done) begin
						step_q <= '0;
						nd_q   <= nd_q + 1'b1;
						if (dvd_nxt == '0) begin
							rd_ptr_q <= nd_q[AW-1:0];
							state_q  <= neg_q ? ST_SIGN : ST_RD;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (rd_ptr_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							rd_ptr_q <= rd_ptr_q - 1'b1;
							state_q  <= ST_RD;
						end
					end
				end
				ST_BAD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dvd_q <= PAD_W'(job_mag);
			rem_q <= '0;
			rad_q <= job_ctl.radix;
			neg_q <= job_ctl.neg;
		end else if (state_q == ST_DIV) begin
			dvd_q <= dvd_nxt;
			rem_q <= digit_done ? '0 : rem_nxt;
		end
		if (state_q == ST_SIGN && out_free) begin
			char_q <= itoa_pkg::CHAR_MINUS;
			bad_q  <= 1'b0;
			last_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			char_q <= rd_data_q;
			bad_q  <= 1'b0;
			last_q <= (rd_ptr_q == '0);
		end else if (state_q == ST_BAD && out_free) begin
			char_q <= itoa_pkg::CHAR_NUL;
			bad_q  <= 1'b1;
			last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (digit_done) begin
			stack_q[nd_q[AW-1:0]] <= itoa_pkg::digit_char(rem_nxt);
		end
		rd_data_q <= stack_q[rd_ptr_q];
	end

	a_nd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nd_q <= ND_W'(VALUE_WIDTH))
		else $error("Digit count exceeds the stack depth.");

	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < rad_q))
		else $error("Partial remainder is not below the radix.");

	a_bad_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && bad_q) |-> (last_q && char_q == itoa_pkg::CHAR_NUL))
		else $error("Error beat is not a single NUL character.");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !bad_q && char_q == itoa_pkg::CHAR_MINUS) |-> !last_q)
		else $error("Minus sign marked as the final character.");

endmodule
